FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the hash engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition holds in the cycle after another one.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/g94h_pkg.sv
// Package: types, constants and functions of the GOST 94 hash engine.
package g94h_pkg;

    localparam int BlockBytes = 32;
    localparam int DigestWords = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLOCK,
        ST_LEN,
        ST_SUM,
        ST_WAIT,
        ST_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_KEY,
        CS_ROUND,
        CS_PSI12,
        CS_PSI1,
        CS_PSI61,
        CS_DONE
    } t_cmp_state;

    typedef struct packed {
        logic start;
        logic done;
        logic busy;
    } t_cmp_ctl;

    localparam logic [255:0] C3 = {
        32'hff00ffff, 32'h000000ff, 32'hff0000ff, 32'h00ffff00,
        32'h00ff00ff, 32'h00ff00ff, 32'hff00ff00, 32'hff00ff00};

    function automatic logic [3:0] sbox(input logic [2:0] row, input logic [3:0] x);
        logic [63:0] r;
        case (row)
            3'd0: r = 64'h3_5_F_7_C_1_B_6_E_0_8_D_2_9_A_4;
            3'd1: r = 64'h9_5_7_0_1_8_3_2_A_F_D_6_C_4_B_E;
            3'd2: r = 64'hB_9_0_6_7_C_F_E_2_4_3_A_D_1_8_5;
            3'd3: r = 64'h3_5_2_B_C_6_4_E_F_9_8_0_1_A_D_7;
            3'd4: r = 64'h2_B_3_0_E_9_A_4_8_D_F_5_1_7_C_6;
            3'd5: r = 64'hE_F_C_9_5_8_6_3_D_1_2_7_0_A_B_4;
            3'd6: r = 64'hC_2_8_6_7_E_A_0_9_5_F_3_1_4_B_D;
            default: r = 64'hC_8_B_6_E_3_2_9_4_A_7_5_0_D_F_1;
        endcase
        return r[{x, 2'b00} +: 4];
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] x);
        logic [31:0] y;
        for (int n = 0; n < 8; n++) begin
            y[4*n +: 4] = sbox(3'(n), x[4*n +: 4]);
        end
        return {y[20:0], y[31:21]};
    endfunction

    function automatic logic [255:0] xform_a(input logic [255:0] y);
        return {y[63:0] ^ y[127:64], y[255:64]};
    endfunction

    function automatic logic [255:0] xform_p(input logic [255:0] w);
        logic [255:0] k;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 4; j++) begin
                k[8*(4*i+j) +: 8] = w[8*(i+8*j) +: 8];
            end
        end
        return k;
    endfunction

    function automatic logic [255:0] psi(input logic [255:0] y);
        logic [15:0] top;
        top = y[15:0] ^ y[31:16] ^ y[47:32] ^ y[63:48] ^ y[207:192] ^ y[255:240];
        return {top, y[255:16]};
    endfunction

endpackage

FILE: rtl/core/g94h_compress.sv
// Compression unit: key schedule, one GOST round per cycle, one psi step per cycle.
`include "assert_macros.svh"
module g94h_compress (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [255:0]   i_h,
    input  logic [255:0]   i_m,
    output logic [255:0]   o_h,
    output logic           o_done
);
    import g94h_pkg::*;

    t_cmp_state    r_st, n_st;
    logic [1:0]    r_q;
    logic [4:0]    r_t;
    logic [5:0]    r_pc;
    logic [255:0]  r_u, r_v, r_key, r_h, r_m, r_s;
    logic [31:0]   r_n1, r_n2;
    logic [2:0]    w_ki;
    logic [31:0]   w_k, w_f;
    logic [255:0]  w_u, w_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= CS_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            CS_IDLE:  if (i_start) n_st = CS_KEY;
            CS_KEY:   n_st = CS_ROUND;
            CS_ROUND: if (r_t == 5'd31) n_st = (r_q == 2'd3) ? CS_PSI12 : CS_KEY;
            CS_PSI12: if (r_pc == 6'd11) n_st = CS_PSI1;
            CS_PSI1:  n_st = CS_PSI61;
            CS_PSI61: if (r_pc == 6'd60) n_st = CS_DONE;
            CS_DONE:  n_st = CS_IDLE;
            default:  n_st = CS_IDLE;
        endcase
    end

    assign w_ki = (r_t < 5'd24) ? r_t[2:0] : ~r_t[2:0];
    assign w_k  = r_key[32*w_ki +: 32];
    assign w_f  = round_fn((r_t[0] ? r_n2 : r_n1) + w_k);
    assign w_u  = (r_q == 2'd0) ? r_u : (xform_a(r_u) ^ ((r_q == 2'd2) ? C3 : 256'd0));
    assign w_v  = (r_q == 2'd0) ? r_v : xform_a(xform_a(r_v));

    always_ff @(posedge i_clk) begin
        case (r_st)
            CS_IDLE: begin
                r_q <= 2'd0;
                r_u <= i_h;
                r_v <= i_m;
                r_h <= i_h;
                r_m <= i_m;
            end
            CS_KEY: begin
                r_u   <= w_u;
                r_v   <= w_v;
                r_key <= xform_p(w_u ^ w_v);
                r_n1  <= r_h[64*r_q +: 32];
                r_n2  <= r_h[64*r_q+32 +: 32];
                r_t   <= 5'd0;
            end
            CS_ROUND: begin
                if (r_t[0]) begin
                    r_n1 <= r_n1 ^ w_f;
                end else begin
                    r_n2 <= r_n2 ^ w_f;
                end
                r_t <= r_t + 5'd1;
                if (r_t == 5'd31) begin
                    r_s[64*r_q +: 64] <= {r_n1 ^ w_f, r_n2};
                    r_q  <= r_q + 2'd1;
                    r_pc <= 6'd0;
                end
            end
            CS_PSI12: begin
                r_s  <= (r_pc == 6'd11) ? psi(r_s) ^ r_m : psi(r_s);
                r_pc <= r_pc + 6'd1;
            end
            CS_PSI1: begin
                r_s  <= psi(r_s) ^ r_h;
                r_pc <= 6'd0;
            end
            CS_PSI61: begin
                r_s  <= psi(r_s);
                r_pc <= r_pc + 6'd1;
            end
            default: begin
                r_pc <= r_pc;
            end
        endcase
    end

    assign o_h    = r_s;
    assign o_done = (r_st == CS_DONE);

    `ASSERT_IMPL(a_done_from_mix, i_clk, i_rst_n, r_st == CS_DONE, $past(r_st) == CS_PSI61)
    `ASSERT_NEXT(a_start_leaves_idle, i_clk, i_rst_n, r_st == CS_IDLE && i_start, r_st == CS_KEY)
endmodule

FILE: rtl/core/gost_94_hash_engine.sv
// Top level: GOST R 34.11-94 hash engine with byte stream in and digest words out.
// A byte that neither fills a block nor is last keeps the engine ready. A full block runs
// a start state, then the compression unit (4 x key setup and rounds, psi, done). A last
// byte runs up to three such compressions, then eight digest words leave one per ready cycle.
// Synchronous active-low reset clears control, chain value, checksum, length and count.
`include "assert_macros.svh"
module gost_94_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import g94h_pkg::*;

    t_top_state    r_st, n_st;
    logic [255:0]  r_hv, r_sum, r_buf;
    logic [63:0]   r_len;
    logic [5:0]    r_cnt;
    logic [2:0]    r_idx;
    logic          r_fin;
    logic          w_take, w_start, w_done;
    logic [255:0]  w_h, w_msg;
    t_cmp_ctl      w_ctl;

    assign s_axis_tready = (r_st == ST_IDLE);
    assign w_take = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st = r_st;
        w_start = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (w_take) begin
                    if (s_axis_tuser && r_cnt == 6'd31) begin
                        n_st = ST_BLOCK;
                    end else if (s_axis_tlast) begin
                        n_st = (r_cnt != 6'd0 || s_axis_tuser) ? ST_BLOCK : ST_LEN;
                    end
                end
            end
            ST_BLOCK, ST_LEN, ST_SUM: begin
                w_start = 1'b1;
                n_st = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_done) begin
                    if (!r_fin) begin
                        n_st = ST_IDLE;
                    end else if (r_cnt == 6'd62) begin
                        n_st = ST_SUM;
                    end else if (r_cnt == 6'd63) begin
                        n_st = ST_OUT;
                    end else begin
                        n_st = ST_LEN;
                    end
                end
            end
            ST_OUT: if (m_axis_tready && r_idx == 3'd7) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_st)
            ST_BLOCK: w_msg = r_buf;
            ST_LEN:   w_msg = {192'd0, r_len};
            default:  w_msg = r_sum;
        endcase
    end

    // r_cnt encodes phase after the last block: 62 = length done, 63 = checksum done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= '0;
            r_sum <= '0;
            r_len <= '0;
            r_buf <= '0;
            r_cnt <= '0;
            r_idx <= '0;
            r_fin <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (w_take) begin
                        r_fin <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            r_buf[8*r_cnt[4:0] +: 8] <= s_axis_tdata;
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end
                end
                ST_BLOCK: begin
                    r_sum <= r_sum + r_buf;
                    r_len <= r_len + {55'd0, r_cnt, 3'd0};
                    r_buf <= '0;
                    r_cnt <= r_fin ? 6'd61 : 6'd0;
                end
                ST_LEN: begin
                    r_cnt <= 6'd62;
                end
                ST_SUM: begin
                    r_cnt <= 6'd63;
                end
                ST_WAIT: begin
                    if (w_done) r_hv <= w_h;
                    if (w_done && r_fin && r_cnt == 6'd61) r_cnt <= 6'd61;
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_hv  <= '0;
                            r_sum <= '0;
                            r_len <= '0;
                            r_cnt <= '0;
                            r_fin <= 1'b0;
                        end
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    assign w_ctl = '{start: w_start, done: w_done, busy: (r_st == ST_WAIT)};

    g94h_compress u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.start),
        .i_h     (r_hv),
        .i_m     (w_msg),
        .o_h     (w_h),
        .o_done  (w_done)
    );

    assign m_axis_tvalid = (r_st == ST_OUT);
    assign m_axis_tdata  = {5'd0, r_idx, r_hv[32*r_idx +: 32]};
    assign m_axis_tlast  = (r_idx == 3'd7);

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_st == ST_WAIT, !s_axis_tready)
    `ASSERT_IMPL(a_out_only_final, i_clk, i_rst_n, m_axis_tvalid, r_cnt == 6'd63)
    `ASSERT_IMPL(a_done_when_busy, i_clk, i_rst_n, w_ctl.done, w_ctl.busy)
endmodule

FILE: tb/gost_94_hash_engine_tb.sv
// Self-checking testbench for the GOST R 34.11-94 hash engine: byte stream in, digest words out.
module gost_94_hash_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import g94h_pkg::DigestWords;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_msg_byte;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last_word;
    } t_digest_word;

    localparam int CycleLimit = 400000;
    localparam int HoldStart = 5000;
    localparam int HoldLen = 3000;
    localparam int QuietStart = 9000;
    localparam int QuietEnd = 14000;

    localparam logic [3:0] SBOX [8][16] = '{
        '{4, 10, 9, 2, 13, 8, 0, 14, 6, 11, 1, 12, 7, 15, 5, 3},
        '{14, 11, 4, 12, 6, 13, 15, 10, 2, 3, 8, 1, 0, 7, 5, 9},
        '{5, 8, 1, 13, 10, 3, 4, 2, 14, 15, 12, 7, 6, 0, 9, 11},
        '{7, 13, 10, 1, 0, 8, 9, 15, 14, 4, 6, 12, 11, 2, 5, 3},
        '{6, 12, 7, 1, 5, 15, 13, 8, 4, 10, 9, 14, 0, 3, 11, 2},
        '{4, 11, 10, 0, 7, 2, 1, 13, 3, 6, 8, 5, 9, 12, 15, 14},
        '{13, 11, 4, 1, 3, 15, 5, 9, 0, 10, 14, 7, 6, 8, 2, 12},
        '{1, 15, 13, 0, 5, 7, 10, 4, 9, 2, 3, 14, 6, 11, 8, 12}};

    localparam logic [255:0] KEY_CONST = {
        32'hff00ffff, 32'h000000ff, 32'hff0000ff, 32'h00ffff00,
        32'h00ff00ff, 32'h00ff00ff, 32'hff00ff00, 32'hff00ff00};

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] byte_present
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;   // last_word

    gost_94_hash_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    t_msg_byte    byte_q[$];
    t_digest_word digest_q[$];
    int           errors = 0;
    int           cycles = 0;
    int           words_checked = 0;
    int           messages = 0;
    logic         word_taken = 1'b0;

    logic [255:0] chain_h;
    logic [255:0] sum_h;
    logic [63:0]  len_bits;
    logic [255:0] blk;
    int           blk_fill;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] gost_f(input logic [31:0] x);
        logic [31:0] y;
        for (int n = 0; n < 8; n++) y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
        return {y[20:0], y[31:21]};
    endfunction

    function automatic logic [255:0] shift_a(input logic [255:0] y);
        return {y[63:0] ^ y[127:64], y[255:64]};
    endfunction

    function automatic logic [255:0] psi_n(input logic [255:0] y, input int n);
        for (int t = 0; t < n; t++)
            y = {y[15:0] ^ y[31:16] ^ y[47:32] ^ y[63:48] ^ y[207:192] ^ y[255:240],
                 y[255:16]};
        return y;
    endfunction

    function automatic logic [255:0] step_hash(input logic [255:0] h, input logic [255:0] m);
        logic [255:0] u, v, w, key, s;
        logic [31:0]  n1, n2;
        int           ki;
        u = h;
        v = m;
        for (int q = 0; q < 4; q++) begin
            if (q > 0) begin
                u = shift_a(u);
                if (q == 2) u = u ^ KEY_CONST;
                v = shift_a(shift_a(v));
            end
            w = u ^ v;
            for (int k = 0; k < 8; k++)
                for (int j = 0; j < 4; j++)
                    key[32*k + 8*j +: 8] = w[8*(k + 8*j) +: 8];
            n1 = h[64*q +: 32];
            n2 = h[64*q + 32 +: 32];
            for (int t = 0; t < 32; t++) begin
                ki = (t < 24) ? (t % 8) : (31 - t);
                if (t % 2 == 0) n2 = n2 ^ gost_f(n1 + key[32*ki +: 32]);
                else n1 = n1 ^ gost_f(n2 + key[32*ki +: 32]);
            end
            s[64*q +: 32] = n2;
            s[64*q + 32 +: 32] = n1;
        end
        s = psi_n(s, 12) ^ m;
        s = psi_n(s, 1) ^ h;
        return psi_n(s, 61);
    endfunction

    task automatic clear_hash();
        chain_h = '0;
        sum_h = '0;
        len_bits = '0;
        blk = '0;
        blk_fill = 0;
    endtask

    task automatic absorb(input int bits);
        sum_h = sum_h + blk;
        chain_h = step_hash(chain_h, blk);
        len_bits = len_bits + 64'(bits);
        blk = '0;
        blk_fill = 0;
    endtask

    task automatic hash_byte(input t_msg_byte b);
        t_digest_word d;
        if (b.present) begin
            blk[8*blk_fill +: 8] = b.data;
            blk_fill++;
            if (blk_fill == 32) absorb(256);
        end
        if (b.last) begin
            if (blk_fill > 0) absorb(blk_fill * 8);
            chain_h = step_hash(chain_h, {192'b0, len_bits});
            chain_h = step_hash(chain_h, sum_h);
            for (int k = 0; k < DigestWords; k++) begin
                d.word = chain_h[32*k +: 32];
                d.index = 3'(k);
                d.last_word = (k == DigestWords - 1);
                digest_q.push_back(d);
            end
            messages++;
            clear_hash();
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    endtask

    function automatic bit idle_roll();
        return (cycles < QuietStart || cycles >= QuietEnd) && $urandom_range(99) < 22;
    endfunction

    always @(posedge i_clk) begin
        t_msg_byte    b;
        t_digest_word d;
        cycles <= cycles + 1;
        word_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            b.data = s_axis_tdata;
            b.present = s_axis_tuser;
            b.last = s_axis_tlast;
            hash_byte(b);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                report("unexpected word", m_axis_tdata[31:0], 32'h0);
            end else begin
                d = digest_q.pop_front();
                words_checked++;
                if (m_axis_tdata[31:0] !== d.word) report("digest_word", m_axis_tdata[31:0], d.word);
                if (m_axis_tdata[34:32] !== d.index)
                    report("word_index", 32'(m_axis_tdata[34:32]), 32'(d.index));
                if (m_axis_tlast !== d.last_word)
                    report("last_word", 32'(m_axis_tlast), 32'(d.last_word));
            end
        end
    end

    always @(negedge i_clk) begin
        t_msg_byte b;
        if (i_rst_n && (!s_axis_tvalid || word_taken)) begin
            if (byte_q.size() == 0 || idle_roll()) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                b = byte_q.pop_front();
                s_axis_tdata <= b.data;
                s_axis_tuser <= b.present;
                s_axis_tlast <= b.last;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (cycles >= HoldStart && cycles < HoldStart + HoldLen) m_axis_tready <= 1'b0;
        else m_axis_tready <= !idle_roll();
    end

    always @(posedge i_clk) begin
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("[gost_94_hash_engine] ERROR");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic present, input logic last);
        t_msg_byte b;
        b.data = data;
        b.present = present;
        b.last = last;
        byte_q.push_back(b);
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || s_axis_tvalid || digest_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int  len;
        int  total;
        bit  ones;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        clear_hash();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hff, 1'b1, 1'b1);
        push_byte(8'h3c, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h80, 1'b1, 1'b0);
        push_byte(8'hff, 1'b0, 1'b1);
        for (int i = 0; i < 18; i++) push_byte(8'hff, 1'b1, i == 17);
        drain();

        total = 0;
        while (total < 280) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(40);
            if ($urandom_range(7) == 0) len = 32 * $urandom_range(2, 1);
            ones = $urandom_range(5) == 0;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(11) == 0) push_byte(8'($urandom), 1'b0, 1'b0);
                push_byte(ones ? 8'hff : 8'($urandom), 1'b1,
                          i == len - 1 && $urandom_range(1) == 1);
            end
            if (len == 0 || !byte_q[$].last) push_byte(8'($urandom), 1'b0, 1'b1);
            total += len + 1;
        end
        drain();
        repeat (50) @(posedge i_clk);

        $display("hashed %0d messages, checked %0d digest words", messages, words_checked);
        if (errors == 0) begin
            $display("[gost_94_hash_engine] OK");
        end else begin
            $display("[gost_94_hash_engine] ERROR");
        end
        $finish;
    end
endmodule
